// File: rtl/crsd_pkg.sv
`timescale 1ns / 1ps
// Shared constants, payload types and register indexes for the cable robot step-delta unit.
// No dependencies; every other file refers to it by scoped names.
package crsd_pkg;

  localparam int COORD_BITS = 20;
  localparam int FRAC_BITS  = 8;
  localparam int SPAN_W     = 20;
  localparam int OUT_W      = 22;
  localparam int CFG_IDX_W  = 4;

  // Axis offsets are kept in half steps, so one extra bit plus a sign bit.
  localparam int OFF_W  = ((COORD_BITS > SPAN_W) ? COORD_BITS : SPAN_W) + 2;
  localparam int MAG_W  = OFF_W - 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int RAD_W  = SUM_W + 2 * FRAC_BITS;
  localparam int ROOT_W = RAD_W / 2;
  localparam int LEN_W  = ROOT_W - 1;
  localparam int REM_W  = ROOT_W + 2;

  localparam int JOBS     = 8;
  localparam int JOB_W    = 3;
  localparam int IQ_DEPTH = 2;
  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPAN_A = 4'd0,
    REG_SPAN_B = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic signed [COORD_BITS-1:0] sz;
    logic signed [COORD_BITS-1:0] tx;
    logic signed [COORD_BITS-1:0] ty;
    logic signed [COORD_BITS-1:0] tz;
  } item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] d1;
    logic signed [OUT_W-1:0] d2;
    logic signed [OUT_W-1:0] d3;
    logic signed [OUT_W-1:0] d4;
  } result_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
  } rad_t;

  typedef struct packed {
    logic             valid;
    logic [LEN_W-1:0] len;
  } root_t;

endpackage

// File: rtl/crsd_ifs.sv
`timescale 1ns / 1ps
// Channel interfaces: setpoint items, delta results and the configuration write channel.
// Depends on crsd_pkg for field widths.
interface crsd_item_if;
  logic valid;
  logic ready;
  logic signed [crsd_pkg::COORD_BITS-1:0] start_x;
  logic signed [crsd_pkg::COORD_BITS-1:0] start_y;
  logic signed [crsd_pkg::COORD_BITS-1:0] start_z;
  logic signed [crsd_pkg::COORD_BITS-1:0] target_x;
  logic signed [crsd_pkg::COORD_BITS-1:0] target_y;
  logic signed [crsd_pkg::COORD_BITS-1:0] target_z;
  modport source (output valid, start_x, start_y, start_z, target_x, target_y, target_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, target_x, target_y, target_z,
                output ready);
endinterface

interface crsd_result_if;
  logic valid;
  logic ready;
  logic signed [crsd_pkg::OUT_W-1:0] delta_cable1;
  logic signed [crsd_pkg::OUT_W-1:0] delta_cable2;
  logic signed [crsd_pkg::OUT_W-1:0] delta_cable3;
  logic signed [crsd_pkg::OUT_W-1:0] delta_cable4;
  modport source (output valid, delta_cable1, delta_cable2, delta_cable3, delta_cable4,
                  input ready);
  modport sink (input valid, delta_cable1, delta_cable2, delta_cable3, delta_cable4,
                output ready);
endinterface

interface crsd_cfg_if;
  logic valid;
  logic ready;
  logic [crsd_pkg::CFG_IDX_W-1:0] index;
  logic [crsd_pkg::SPAN_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/crsd_front.sv
`timescale 1ns / 1ps
// Front end: accepts setpoint transactions into a two-entry queue.
// Depends on crsd_pkg and crsd_item_if.
module crsd_front (
  input  logic                clk,
  input  logic                rst,
  crsd_item_if.sink           setpoint,
  output crsd_pkg::item_t     head,
  output logic                head_valid,
  input  logic                pop
);

  crsd_pkg::item_t q [crsd_pkg::IQ_DEPTH];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       push;

  assign setpoint.ready = (count < 2'(crsd_pkg::IQ_DEPTH));
  assign push           = setpoint.valid && setpoint.ready;
  assign head_valid     = (count != 2'd0);
  assign head           = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= '{sx: setpoint.start_x, sy: setpoint.start_y, sz: setpoint.start_z,
                 tx: setpoint.target_x, ty: setpoint.target_y, tz: setpoint.target_z};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: rtl/crsd_issue.sv
`timescale 1ns / 1ps
// Issue stage: holds the span registers, walks each item through its eight distances
// and forms the squared distance sums. Depends on crsd_pkg and crsd_cfg_if.
module crsd_issue (
  input  logic            clk,
  input  logic            rst,
  crsd_cfg_if.sink        cfg,
  input  crsd_pkg::item_t head,
  input  logic            head_valid,
  output logic            pop,
  input  logic            out_done,
  output crsd_pkg::rad_t  rad
);

  logic [crsd_pkg::SPAN_W-1:0]  span_a;
  logic [crsd_pkg::SPAN_W-1:0]  span_b;
  logic [crsd_pkg::OQ_AW:0]     inflight;
  crsd_pkg::item_t              cur;
  logic                         busy;
  logic [crsd_pkg::JOB_W-1:0]   job;
  logic                         last_job;

  logic signed [crsd_pkg::COORD_BITS-1:0] x, y, z;
  logic signed [crsd_pkg::OFF_W-1:0]      x2, y2, z2, ax, bx, dx, dy, dz;
  logic signed [crsd_pkg::OFF_W-1:0]      ndx, ndy, ndz;

  logic                        v1, v2;
  logic [crsd_pkg::MAG_W-1:0]  mx, my, mz;
  logic [crsd_pkg::SQ_W-1:0]   sqx, sqy, sqz;
  logic [crsd_pkg::SUM_W-1:0]  rad_sum;
  logic                        rad_valid;

  assign cfg.ready = 1'b1;
  assign rad       = '{valid: rad_valid, sum: rad_sum};

  always_ff @(posedge clk) begin
    if (rst) begin
      span_a <= '0;
      span_b <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        crsd_pkg::REG_SPAN_A: span_a <= cfg.data;
        crsd_pkg::REG_SPAN_B: span_b <= cfg.data;
        default: ;
      endcase
    end
  end

  assign last_job = (job == crsd_pkg::JOB_W'(crsd_pkg::JOBS - 1));
  // A new item starts only when the output queue is sure to have room for it.
  assign pop = head_valid && (inflight < (crsd_pkg::OQ_AW + 1)'(crsd_pkg::OQ_DEPTH))
               && (!busy || last_job);

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      job      <= '0;
      inflight <= '0;
    end else begin
      inflight <= inflight + (crsd_pkg::OQ_AW + 1)'(pop) - (crsd_pkg::OQ_AW + 1)'(out_done);
      if (pop) begin
        busy <= 1'b1;
        job  <= '0;
      end else if (busy) begin
        job <= job + 1'b1;
        if (last_job) busy <= 1'b0;
      end
    end
  end

  // Job bit 0 picks start or target; bits 2:1 name the cable.
  always_comb begin
    x   = job[0] ? cur.tx : cur.sx;
    y   = job[0] ? cur.ty : cur.sy;
    z   = job[0] ? cur.tz : cur.sz;
    x2  = crsd_pkg::OFF_W'(x) <<< 1;
    y2  = crsd_pkg::OFF_W'(y) <<< 1;
    z2  = crsd_pkg::OFF_W'(z) <<< 1;
    bx  = crsd_pkg::OFF_W'(span_b);
    ax  = crsd_pkg::OFF_W'(span_a);
    dx  = job[1] ? (bx - x2) : (bx + x2);
    dy  = job[2] ? (ax + y2) : (ax - y2);
    dz  = z2;
    ndx = -dx;
    ndy = -dy;
    ndz = -dz;
  end

  always_ff @(posedge clk) begin
    mx  <= dx[crsd_pkg::OFF_W-1] ? ndx[crsd_pkg::MAG_W-1:0] : dx[crsd_pkg::MAG_W-1:0];
    my  <= dy[crsd_pkg::OFF_W-1] ? ndy[crsd_pkg::MAG_W-1:0] : dy[crsd_pkg::MAG_W-1:0];
    mz  <= dz[crsd_pkg::OFF_W-1] ? ndz[crsd_pkg::MAG_W-1:0] : dz[crsd_pkg::MAG_W-1:0];
    sqx <= mx * mx;
    sqy <= my * my;
    sqz <= mz * mz;
    rad_sum <= crsd_pkg::SUM_W'(sqx) + crsd_pkg::SUM_W'(sqy) + crsd_pkg::SUM_W'(sqz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      rad_valid <= 1'b0;
    end else begin
      v1        <= busy;
      v2        <= v1;
      rad_valid <= v2;
    end
  end

  a_inflight_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= (crsd_pkg::OQ_AW + 1)'(crsd_pkg::OQ_DEPTH))
    else $error("more items in flight than the output queue holds");

  a_job_walk: assert property (@(posedge clk) disable iff (rst)
    busy && !last_job |=> busy && (job == $past(job) + 1'b1))
    else $error("job sequence broke off before the eighth distance");

  a_start_needs_item: assert property (@(posedge clk) disable iff (rst)
    pop |=> busy && (job == '0))
    else $error("item start did not restart the job sequence");

endmodule

// File: rtl/crsd_sqrt.sv
`timescale 1ns / 1ps
// Pipelined digit-by-digit square root, one result bit per stage, no stalls.
// Gives floor(sqrt(sum) * 2^FRAC_BITS) / 2. Depends on crsd_pkg.
module crsd_sqrt (
  input  logic            clk,
  input  logic            rst,
  input  crsd_pkg::rad_t  rad,
  output crsd_pkg::root_t root
);

  localparam int ST = crsd_pkg::ROOT_W;

  logic                        v    [1:ST];
  logic [crsd_pkg::RAD_W-1:0]  opnd [1:ST];
  logic [crsd_pkg::ROOT_W-1:0] rt   [1:ST];
  logic [crsd_pkg::REM_W-1:0]  rm   [1:ST];

  for (genvar i = 0; i < ST; i++) begin : g_stage
    logic                        v_in;
    logic [crsd_pkg::RAD_W-1:0]  opnd_in;
    logic [crsd_pkg::ROOT_W-1:0] rt_in;
    logic [crsd_pkg::REM_W-1:0]  rm_in;
    logic [crsd_pkg::REM_W-1:0]  rem_sh;
    logic [crsd_pkg::REM_W-1:0]  trial;
    logic                        ge;

    if (i == 0) begin : g_first
      assign v_in    = rad.valid;
      assign opnd_in = crsd_pkg::RAD_W'(rad.sum) << (2 * crsd_pkg::FRAC_BITS);
      assign rt_in   = '0;
      assign rm_in   = '0;
    end else begin : g_rest
      assign v_in    = v[i];
      assign opnd_in = opnd[i];
      assign rt_in   = rt[i];
      assign rm_in   = rm[i];
    end

    assign rem_sh = {rm_in[crsd_pkg::REM_W-3:0], opnd_in[crsd_pkg::RAD_W-1 -: 2]};
    assign trial  = {rt_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      opnd[i+1] <= opnd_in << 2;
      rt[i+1]   <= {rt_in[crsd_pkg::ROOT_W-2:0], ge};
      rm[i+1]   <= ge ? (rem_sh - trial) : rem_sh;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else begin
        v[i+1] <= v_in;
      end
    end
  end

  assign root.valid = v[ST];
  assign root.len   = rt[ST][crsd_pkg::ROOT_W-1:1];

endmodule

// File: rtl/crsd_collect.sv
`timescale 1ns / 1ps
// Back end: gathers the eight cable lengths of an item, forms the four truncated
// deltas and queues them for the result channel. Depends on crsd_pkg and crsd_result_if.
module crsd_collect (
  input  logic            clk,
  input  logic            rst,
  input  crsd_pkg::root_t root,
  crsd_result_if.source   deltas,
  output logic            out_done
);

  logic [crsd_pkg::LEN_W-1:0] lens [crsd_pkg::JOBS];
  logic [crsd_pkg::JOB_W-1:0] cnt;
  logic                       done_r;

  crsd_pkg::result_t        oq [crsd_pkg::OQ_DEPTH];
  logic [crsd_pkg::OQ_AW-1:0] wp;
  logic [crsd_pkg::OQ_AW-1:0] rp;
  logic [crsd_pkg::OQ_AW:0]   ocnt;
  crsd_pkg::result_t          res;

  // Difference truncated toward zero, saturated to the output range.
  function automatic logic signed [crsd_pkg::OUT_W-1:0] trunc_delta(
    input logic [crsd_pkg::LEN_W-1:0] ls,
    input logic [crsd_pkg::LEN_W-1:0] lt
  );
    logic signed [crsd_pkg::LEN_W:0] d;
    logic [crsd_pkg::LEN_W:0]        mag;
    logic [crsd_pkg::LEN_W:0]        q;
    logic                            neg;
    d   = $signed({1'b0, ls}) - $signed({1'b0, lt});
    neg = d[crsd_pkg::LEN_W];
    mag = neg ? (crsd_pkg::LEN_W + 1)'(-d) : (crsd_pkg::LEN_W + 1)'(d);
    q   = mag >> crsd_pkg::FRAC_BITS;
    if (!neg && (q > (crsd_pkg::LEN_W + 1)'((64'd1 << (crsd_pkg::OUT_W - 1)) - 64'd1))) begin
      q = (crsd_pkg::LEN_W + 1)'((64'd1 << (crsd_pkg::OUT_W - 1)) - 64'd1);
    end else if (neg && (q > (crsd_pkg::LEN_W + 1)'(64'd1 << (crsd_pkg::OUT_W - 1)))) begin
      q = (crsd_pkg::LEN_W + 1)'(64'd1 << (crsd_pkg::OUT_W - 1));
    end
    trunc_delta = neg ? crsd_pkg::OUT_W'(-q) : crsd_pkg::OUT_W'(q);
  endfunction

  always_ff @(posedge clk) begin
    if (root.valid) lens[cnt] <= root.len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= root.valid && (cnt == crsd_pkg::JOB_W'(crsd_pkg::JOBS - 1));
      if (root.valid) cnt <= cnt + 1'b1;
    end
  end

  // Even slots hold start lengths, odd slots target lengths.
  always_comb begin
    res.d1 = trunc_delta(lens[0], lens[1]);
    res.d2 = trunc_delta(lens[2], lens[3]);
    res.d3 = trunc_delta(lens[4], lens[5]);
    res.d4 = trunc_delta(lens[6], lens[7]);
  end

  assign out_done            = deltas.valid && deltas.ready;
  assign deltas.valid        = (ocnt != '0);
  assign deltas.delta_cable1 = oq[rp].d1;
  assign deltas.delta_cable2 = oq[rp].d2;
  assign deltas.delta_cable3 = oq[rp].d3;
  assign deltas.delta_cable4 = oq[rp].d4;

  always_ff @(posedge clk) begin
    if (done_r) oq[wp] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      ocnt <= '0;
    end else begin
      if (done_r) wp <= wp + 1'b1;
      if (out_done) rp <= rp + 1'b1;
      ocnt <= ocnt + (crsd_pkg::OQ_AW + 1)'(done_r) - (crsd_pkg::OQ_AW + 1)'(out_done);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    done_r |-> (ocnt < (crsd_pkg::OQ_AW + 1)'(crsd_pkg::OQ_DEPTH)) || out_done)
    else $error("result pushed into a full output queue");

  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done_r |=> !done_r)
    else $error("two completions on consecutive cycles");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ocnt <= (crsd_pkg::OQ_AW + 1)'(crsd_pkg::OQ_DEPTH))
    else $error("output queue count out of range");

endmodule

// File: rtl/cable_robot_step_deltas_unit.sv
`timescale 1ns / 1ps
// The eight root computations of an item share one pipelined square-root unit that takes
// one distance per cycle while an item is being walked; a new item starts as the last distance
// of the one before issues, provided a setpoint is queued and the output queue has room for it.
// Up to eight issued items plus two queued setpoints are held; an eight-entry result queue
// absorbs output stalls.
// Reset (rst, synchronous, active high) empties all queues and clears span_a and span_b.
module cable_robot_step_deltas_unit (
  input  logic          clk,
  input  logic          rst,
  crsd_item_if.sink     setpoint,
  crsd_result_if.source deltas,
  crsd_cfg_if.sink      cfg
);

  crsd_pkg::item_t head;
  logic            head_valid;
  logic            pop;
  logic            out_done;
  crsd_pkg::rad_t  rad;
  crsd_pkg::root_t root;

  crsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .setpoint   (setpoint),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  crsd_issue u_issue (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_done   (out_done),
    .rad        (rad)
  );

  crsd_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .rad  (rad),
    .root (root)
  );

  crsd_collect u_collect (
    .clk      (clk),
    .rst      (rst),
    .root     (root),
    .deltas   (deltas),
    .out_done (out_done)
  );

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for cable_robot_step_deltas_unit: random and directed setpoints,
// span register writes between phases, and a bit-exact predictor of the four cable deltas.
// Depends on crsd_pkg, the channel interfaces in crsd_ifs.sv and the unit itself.
module testbench;

  localparam int DRAIN_CYCLES = 120;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst;

  crsd_item_if   setpoint ();
  crsd_result_if deltas ();
  crsd_cfg_if    cfg ();

  cable_robot_step_deltas_unit dut (
    .clk(clk),
    .rst(rst),
    .setpoint(setpoint.sink),
    .deltas(deltas.source),
    .cfg(cfg.sink)
  );

  // Predictor state: the two spans as the unit should hold them.
  logic [crsd_pkg::SPAN_W-1:0] model_span_a;
  logic [crsd_pkg::SPAN_W-1:0] model_span_b;

  crsd_pkg::item_t   pending_items[$];
  crsd_pkg::result_t expected_deltas[$];

  int errors;
  int items_sent;
  int results_seen;
  int idle_cycles;
  bit timed_out;
  bit sink_idle_en;
  bit source_idle_en;
  bit sink_hold;
  bit source_pause;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // floor(sqrt(s) * 2^FRAC_BITS), bit by bit.
  function automatic longint unsigned frac_sqrt(input longint unsigned s);
    longint unsigned root;
    longint unsigned rem;
    longint unsigned trial;
    longint unsigned pair;
    int i;
    root = 0;
    rem = 0;
    for (i = 31; i >= -crsd_pkg::FRAC_BITS; i--) begin
      pair = (i >= 0) ? ((s >> (2 * i)) & 64'd3) : 64'd0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // Cable length with FRAC_BITS fraction; offsets are in half steps.
  function automatic longint unsigned cable_length(input int xs, input int ys,
                                                   input longint x, input longint y,
                                                   input longint z);
    longint dx;
    longint dy;
    longint dz;
    longint unsigned s;
    dx = longint'(model_span_b) + xs * 2 * x;
    dy = longint'(model_span_a) + ys * 2 * y;
    dz = 2 * z;
    s = dx * dx + dy * dy + dz * dz;
    return frac_sqrt(s) >> 1;
  endfunction

  function automatic logic signed [crsd_pkg::OUT_W-1:0] trunc_delta(
    input longint unsigned ls,
    input longint unsigned lt
  );
    longint d;
    longint r;
    longint hi;
    hi = (longint'(1) << (crsd_pkg::OUT_W - 1)) - 1;
    d = longint'(ls) - longint'(lt);
    if (d >= 0) r = d >>> crsd_pkg::FRAC_BITS;
    else r = -((-d) >>> crsd_pkg::FRAC_BITS);
    if (r > hi) r = hi;
    if (r < -hi - 1) r = -hi - 1;
    return r[crsd_pkg::OUT_W-1:0];
  endfunction

  function automatic crsd_pkg::result_t predict_deltas(input crsd_pkg::item_t it);
    crsd_pkg::result_t res;
    int xs[4];
    int ys[4];
    logic signed [crsd_pkg::OUT_W-1:0] d[4];
    int k;
    xs = '{1, -1, 1, -1};
    ys = '{-1, -1, 1, 1};
    for (k = 0; k < 4; k++) begin
      d[k] = trunc_delta(cable_length(xs[k], ys[k], it.sx, it.sy, it.sz),
                         cable_length(xs[k], ys[k], it.tx, it.ty, it.tz));
    end
    res.d1 = d[0];
    res.d2 = d[1];
    res.d3 = d[2];
    res.d4 = d[3];
    return res;
  endfunction

  function automatic logic signed [crsd_pkg::COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return logic'($urandom_range(0, 1)) ? -20'sd524288 : 20'sd524287;
      1: return $signed(crsd_pkg::COORD_BITS'($urandom_range(0, 64))) - 20'sd32;
      2: return $signed(crsd_pkg::COORD_BITS'($urandom_range(0, 4096))) - 20'sd2048;
      default: return $signed(crsd_pkg::COORD_BITS'($urandom));
    endcase
  endfunction

  function automatic crsd_pkg::item_t rand_item();
    crsd_pkg::item_t it;
    it.sx = rand_coord();
    it.sy = rand_coord();
    it.sz = rand_coord();
    // Small moves are the normal use; keep many targets near the start point.
    if ($urandom_range(0, 1)) begin
      it.tx = it.sx + $signed(crsd_pkg::COORD_BITS'($urandom_range(0, 400))) - 20'sd200;
      it.ty = it.sy + $signed(crsd_pkg::COORD_BITS'($urandom_range(0, 400))) - 20'sd200;
      it.tz = it.sz + $signed(crsd_pkg::COORD_BITS'($urandom_range(0, 400))) - 20'sd200;
    end else begin
      it.tx = rand_coord();
      it.ty = rand_coord();
      it.tz = rand_coord();
    end
    return it;
  endfunction

  function automatic crsd_pkg::item_t make_item(input int sx, input int sy, input int sz,
                                                input int tx, input int ty, input int tz);
    crsd_pkg::item_t it;
    it.sx = sx[crsd_pkg::COORD_BITS-1:0];
    it.sy = sy[crsd_pkg::COORD_BITS-1:0];
    it.sz = sz[crsd_pkg::COORD_BITS-1:0];
    it.tx = tx[crsd_pkg::COORD_BITS-1:0];
    it.ty = ty[crsd_pkg::COORD_BITS-1:0];
    it.tz = tz[crsd_pkg::COORD_BITS-1:0];
    return it;
  endfunction

  // Driver: the item is predicted at the edge where its transaction completes.
  always @(posedge clk) begin
    if (rst) begin
      setpoint.valid <= 1'b0;
    end else begin
      if (setpoint.valid && setpoint.ready) begin
        expected_deltas.push_back(predict_deltas({setpoint.start_x, setpoint.start_y,
                                                  setpoint.start_z, setpoint.target_x,
                                                  setpoint.target_y, setpoint.target_z}));
        items_sent++;
      end
      if ((!setpoint.valid || setpoint.ready) ) begin
        if (pending_items.size() > 0 && !source_pause &&
            !(source_idle_en && $urandom_range(0, 99) < 32)) begin
          crsd_pkg::item_t it;
          it = pending_items.pop_front();
          setpoint.valid <= 1'b1;
          setpoint.start_x <= it.sx;
          setpoint.start_y <= it.sy;
          setpoint.start_z <= it.sz;
          setpoint.target_x <= it.tx;
          setpoint.target_y <= it.ty;
          setpoint.target_z <= it.tz;
        end else begin
          setpoint.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result transaction with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      deltas.ready <= 1'b0;
    end else begin
      if (deltas.valid && deltas.ready) begin
        results_seen++;
        if (expected_deltas.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %0d %0d %0d %0d", $time, deltas.delta_cable1,
                   deltas.delta_cable2, deltas.delta_cable3, deltas.delta_cable4);
        end else begin
          crsd_pkg::result_t exp_res;
          exp_res = expected_deltas.pop_front();
          if (exp_res.d1 !== deltas.delta_cable1) begin
            errors++;
            $display("%0t: delta_cable1 expected %0d actual %0d", $time, exp_res.d1,
                     deltas.delta_cable1);
          end
          if (exp_res.d2 !== deltas.delta_cable2) begin
            errors++;
            $display("%0t: delta_cable2 expected %0d actual %0d", $time, exp_res.d2,
                     deltas.delta_cable2);
          end
          if (exp_res.d3 !== deltas.delta_cable3) begin
            errors++;
            $display("%0t: delta_cable3 expected %0d actual %0d", $time, exp_res.d3,
                     deltas.delta_cable3);
          end
          if (exp_res.d4 !== deltas.delta_cable4) begin
            errors++;
            $display("%0t: delta_cable4 expected %0d actual %0d", $time, exp_res.d4,
                     deltas.delta_cable4);
          end
        end
      end
      deltas.ready <= !sink_hold && !(sink_idle_en && $urandom_range(0, 99) < 32);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (setpoint.valid && setpoint.ready) || (deltas.valid && deltas.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        timed_out = 1'b1;
      end
    end
  end

  // The trailing edge keeps back-to-back writes from driving valid twice in one step.
  task automatic write_span(input crsd_pkg::cfg_reg_t idx,
                            input logic [crsd_pkg::SPAN_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    if (idx == crsd_pkg::REG_SPAN_A) model_span_a = value;
    else if (idx == crsd_pkg::REG_SPAN_B) model_span_b = value;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while ((pending_items.size() > 0 || setpoint.valid || expected_deltas.size() > 0) &&
           !timed_out) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [crsd_pkg::SPAN_W-1:0] a,
                           input logic [crsd_pkg::SPAN_W-1:0] b,
                           input int count);
    int i;
    write_span(crsd_pkg::REG_SPAN_A, a);
    write_span(crsd_pkg::REG_SPAN_B, b);
    for (i = 0; i < count; i++) pending_items.push_back(rand_item());
    wait_drained();
  endtask

  // Long receiver stall while the sender keeps offering, counted here.
  initial begin
    sink_hold = 1'b0;
    wait (!rst);
    wait (items_sent >= 60);
    @(posedge clk);
    sink_hold = 1'b1;
    repeat (300) @(posedge clk);
    sink_hold = 1'b0;
  end

  initial begin
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    timed_out = 1'b0;
    sink_idle_en = 1'b0;
    source_idle_en = 1'b0;
    source_pause = 1'b0;
    model_span_a = '0;
    model_span_b = '0;
    rst = 1'b1;
    setpoint.valid = 1'b0;
    setpoint.start_x = '0;
    setpoint.start_y = '0;
    setpoint.start_z = '0;
    setpoint.target_x = '0;
    setpoint.target_y = '0;
    setpoint.target_z = '0;
    deltas.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = crsd_pkg::REG_SPAN_A;
    cfg.data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset spans (zero spacing), then coordinate extremes.
    pending_items.push_back(make_item(0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(10, -20, 30, -10, 20, -30));
    wait_drained();
    write_span(crsd_pkg::REG_SPAN_A, 20'hFFFFF);
    write_span(crsd_pkg::REG_SPAN_B, 20'hFFFFF);
    pending_items.push_back(make_item(-524288, -524288, -524288, 524287, 524287, 524287));
    pending_items.push_back(make_item(524287, 524287, 524287, -524288, -524288, -524288));
    pending_items.push_back(make_item(524287, -524288, 524287, -524288, 524287, -524288));
    pending_items.push_back(make_item(-1, -1, -1, 0, 0, 0));
    pending_items.push_back(make_item(0, 0, 0, -1, -1, -1));
    pending_items.push_back(make_item(1, 1, 1, 1, 1, 1));
    pending_items.push_back(make_item(-524288, 0, 0, -524288, 0, 1));
    wait_drained();
    write_span(crsd_pkg::REG_SPAN_A, 20'd1);
    write_span(crsd_pkg::REG_SPAN_B, 20'd0);
    pending_items.push_back(make_item(0, 0, 0, 0, 0, 1));
    pending_items.push_back(make_item(0, 0, 5, 0, 0, -5));
    pending_items.push_back(make_item(3, 4, 0, -3, -4, 0));
    pending_items.push_back(make_item(524287, 524287, 0, 0, 0, 524287));
    // Unknown register index must leave the spans alone.
    wait_drained();
    cfg.valid <= 1'b1;
    cfg.index <= crsd_pkg::CFG_IDX_W'(4'hF);
    cfg.data <= 20'h12345;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    pending_items.push_back(make_item(100, 200, 300, 101, 199, 302));
    pending_items.push_back(make_item(-100, -200, -300, -99, -201, -302));
    wait_drained();

    // Random phases; the first without idling, the rest with random gaps.
    run_phase(20'd1000, 20'd2000, 150);
    sink_idle_en = 1'b1;
    source_idle_en = 1'b1;
    run_phase(20'hFFFFF, 20'd0, 150);
    run_phase(20'd0, 20'hFFFFF, 150);
    // Sender pauses part way through a batch until every expected result has come.
    for (int n = 0; n < 30; n++) pending_items.push_back(rand_item());
    repeat (40) @(posedge clk);
    source_pause = 1'b1;
    while ((expected_deltas.size() > 0 || setpoint.valid) && !timed_out) @(posedge clk);
    source_pause = 1'b0;
    wait_drained();
    run_phase(20'($urandom), 20'($urandom), 200);
    run_phase(20'd3, 20'd7, 150);
    run_phase(20'($urandom), 20'($urandom), 220);
    wait_drained();

    $display("Covered %0d setpoints and %0d results over nine span settings,", items_sent,
             results_seen);
    $display("including span extremes, coordinate extremes and long output stalls.");
    if (errors == 0 && !timed_out) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    wait (timed_out);
    $display("Watchdog expired after %0d idle cycles.", WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

endmodule
